@@ hw/rtl/u8s_pkg.sv @@
// shared types and constants of the utf-8 sanitizer
// byte classes, queue item, replacement sequence and code point limits
// no dependencies
`timescale 1ns / 1ps

package u8s_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned WIN_DEPTH   = 4;

  // replacement character U+FFFD as utf-8
  localparam logic [7:0] REPL_BYTE0 = 8'hEF;
  localparam logic [7:0] REPL_BYTE1 = 8'hBF;
  localparam logic [7:0] REPL_BYTE2 = 8'hBD;

  localparam logic [20:0] CP_MIN2    = 21'h000080;
  localparam logic [20:0] CP_MIN3    = 21'h000800;
  localparam logic [20:0] CP_MIN4    = 21'h010000;
  localparam logic [20:0] CP_SURR_LO = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI = 21'h00DFFF;
  localparam logic [20:0] CP_MAX     = 21'h10FFFF;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } cls_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    cls_e       cls;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPL,
    ST_COPY
  } st_e;

endpackage

@@ hw/rtl/u8s_if.sv @@
// request channels of the utf-8 sanitizer: raw input and sanitized output
// valid/ready handshake, no dependencies
`timescale 1ns / 1ps

interface u8s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface u8s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_last;

  modport source (output valid, output out_byte, output run_last, output stream_last,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input stream_last,
                  output ready);
endinterface

@@ hw/rtl/utf8_lossy_sanitizer_core.sv @@
// top level of the utf-8 sanitizer: byte classifier and queue feeding the sequencer
// depends on u8s_pkg, u8s_if, u8s_front and u8s_back
`timescale 1ns / 1ps

// Streaming UTF-8 sanitizer. Raw bytes enter on in_i with an end-of-stream mark and
// sanitized bytes leave on out_o, one byte per cycle at most. ASCII text flows at one
// byte per cycle while out_o is ready. A byte that only opens or extends a multi-byte
// window produces nothing, but a window still open at the end of a stream is replaced.
// The byte completing a window of L bytes is checked first; then the L bytes are copied
// out when the sequence is valid, or one replacement (EF BF BD) is written when it is
// not, after which the bytes behind the lead are rescanned. A step with results closes
// by marking its last byte. The back-end sequencer writes at most one output byte a
// cycle and waits while out_o holds a byte not yet taken; the input queue (QueueDepth
// items) keeps accepting bytes meanwhile until it is full. run_last marks the last byte
// produced for an input byte, stream_last the last byte of a stream.
module utf8_lossy_sanitizer_core #(
  parameter int unsigned QueueDepth = u8s_pkg::QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  u8s_in_if.sink    in_i,
  u8s_out_if.source out_o
);
  import u8s_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  u8s_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_ready_i (q_ready)
  );

  u8s_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_ready_o (q_ready),
    .out_o     (out_o)
  );

endmodule

@@ hw/rtl/u8s_front.sv @@
// front end: classifies each raw byte and queues it for the sequencer
// depends on u8s_pkg and u8s_in_if
`timescale 1ns / 1ps

module u8s_front #(
  parameter int unsigned Depth = u8s_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  u8s_in_if.sink         in_i,
  output logic           q_valid_o,
  output u8s_pkg::item_t q_item_o,
  input  logic           q_ready_i
);
  import u8s_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;
  cls_e             cls;
  item_t            new_item;

  always_comb begin
    unique case (in_i.in_byte) inside
      [8'h00:8'h7F]: cls = CLS_ASCII;
      [8'hC2:8'hDF]: cls = CLS_LEAD2;
      [8'hE0:8'hEF]: cls = CLS_LEAD3;
      [8'hF0:8'hF4]: cls = CLS_LEAD4;
      default:       cls = CLS_BAD;
    endcase
  end

  assign new_item = '{data: in_i.in_byte, last: in_i.in_last, cls: cls};

  assign in_i.ready = (cnt_q != CntW'(Depth));
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(Depth)) |=> (cnt_q == CntW'(Depth)) || $past(pop))
    else $error("queue count dropped without a pop");
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");
  a_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |=> (cnt_q == '0) || $past(push))
    else $error("queue filled without a push");
`endif

endmodule

@@ hw/rtl/u8s_back.sv @@
// back end: sequencer that checks windows and emits sanitized bytes, at most one a cycle
// depends on u8s_pkg and u8s_out_if
`timescale 1ns / 1ps

module u8s_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  u8s_pkg::item_t q_item_i,
  output logic           q_ready_o,
  u8s_out_if.source      out_o
);
  import u8s_pkg::*;

  function automatic logic win_ok(input logic [3:0][7:0] w, input logic [2:0] len);
    logic [20:0] cp;
    logic [20:0] cp_min;
    logic        cont_ok;
    cont_ok = (w[1][7:6] == 2'b10);
    if (len >= 3'd3) cont_ok = cont_ok && (w[2][7:6] == 2'b10);
    if (len == 3'd4) cont_ok = cont_ok && (w[3][7:6] == 2'b10);
    case (len)
      3'd2: begin
        cp     = {10'd0, w[0][4:0], w[1][5:0]};
        cp_min = CP_MIN2;
      end
      3'd3: begin
        cp     = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
        cp_min = CP_MIN3;
      end
      default: begin
        cp     = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
        cp_min = CP_MIN4;
      end
    endcase
    return cont_ok && (cp >= cp_min) && !((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI)) &&
           (cp <= CP_MAX);
  endfunction

  st_e             state_q, state_d;
  logic [3:0][7:0] win_q, win_d;
  cls_e            win_cls_q [WIN_DEPTH];
  cls_e            win_cls_d [WIN_DEPTH];
  logic [2:0]      cnt_q, cnt_d;
  logic            last_q, last_d;
  logic [1:0]      rep_q, rep_d;
  logic            drop_q, drop_d;
  logic [2:0]      copy_q, copy_d;
  logic            hold_vld_q, hold_vld_d;
  logic [7:0]      hold_byte_q, hold_byte_d;
  logic            out_vld_q, out_vld_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_run_q, out_run_d;
  logic            out_stream_q, out_stream_d;

  logic            go;
  cls_e            cur_cls;
  logic [2:0]      cur_len;
  logic            win_full;
  logic            cur_ok;
  logic            emit, shift, finish, fast, take;
  logic [7:0]      emit_byte;
  logic [1:0]      take_idx;

  assign go       = !out_vld_q || out_o.ready;
  assign cur_cls  = win_cls_q[0];
  assign win_full = (cur_len <= cnt_q);
  assign cur_ok   = win_ok(win_q, cur_len);

  always_comb begin
    unique case (cur_cls)
      CLS_LEAD2: cur_len = 3'd2;
      CLS_LEAD3: cur_len = 3'd3;
      CLS_LEAD4: cur_len = 3'd4;
      default:   cur_len = 3'd0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (go) begin
          if (cnt_q == 3'd0) begin
            state_d = q_valid_i ? ST_SCAN : ST_IDLE;
          end else begin
            unique case (cur_cls)
              CLS_ASCII: begin
                if (cnt_q == 3'd1 && !hold_vld_q) state_d = q_valid_i ? ST_SCAN : ST_IDLE;
              end
              CLS_BAD: state_d = ST_REPL;
              default: begin
                if (!win_full) begin
                  state_d = last_q ? ST_REPL : (q_valid_i ? ST_SCAN : ST_IDLE);
                end else begin
                  state_d = cur_ok ? ST_COPY : ST_REPL;
                end
              end
            endcase
          end
        end
      end
      ST_REPL: begin
        if (go && rep_q == 2'd2) state_d = ST_SCAN;
      end
      ST_COPY: begin
        if (go && copy_q == 3'd1) state_d = ST_SCAN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // actions and datapath
  always_comb begin
    win_d        = win_q;
    win_cls_d    = win_cls_q;
    cnt_d        = cnt_q;
    last_d       = last_q;
    rep_d        = rep_q;
    drop_d       = drop_q;
    copy_d       = copy_q;
    hold_vld_d   = hold_vld_q;
    hold_byte_d  = hold_byte_q;
    out_vld_d    = out_vld_q;
    out_byte_d   = out_byte_q;
    out_run_d    = out_run_q;
    out_stream_d = out_stream_q;
    q_ready_o    = 1'b0;
    emit         = 1'b0;
    emit_byte    = win_q[0];
    shift        = 1'b0;
    finish       = 1'b0;
    fast         = 1'b0;
    take         = 1'b0;
    take_idx     = cnt_q[1:0];

    if (out_o.ready) out_vld_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        take = 1'b1;
      end
      ST_SCAN: begin
        if (go) begin
          if (cnt_q == 3'd0) begin
            finish = 1'b1;
          end else begin
            unique case (cur_cls)
              CLS_ASCII: begin
                if (cnt_q == 3'd1 && !hold_vld_q) begin
                  fast = 1'b1;
                end else begin
                  emit  = 1'b1;
                  shift = 1'b1;
                end
              end
              CLS_BAD: begin
                rep_d  = 2'd0;
                drop_d = 1'b0;
              end
              default: begin
                if (!win_full) begin
                  // open window: replaced and dropped at stream end, else kept
                  if (last_q) begin
                    rep_d  = 2'd0;
                    drop_d = 1'b1;
                  end else begin
                    finish = 1'b1;
                  end
                end else if (cur_ok) begin
                  copy_d = cur_len;
                end else begin
                  rep_d  = 2'd0;
                  drop_d = 1'b0;
                end
              end
            endcase
          end
        end
      end
      ST_REPL: begin
        if (go) begin
          emit = 1'b1;
          case (rep_q)
            2'd0:    emit_byte = REPL_BYTE0;
            2'd1:    emit_byte = REPL_BYTE1;
            default: emit_byte = REPL_BYTE2;
          endcase
          if (rep_q == 2'd2) begin
            rep_d = 2'd0;
            if (drop_q) cnt_d = 3'd0;
            else        shift = 1'b1;
          end else begin
            rep_d = rep_q + 2'd1;
          end
        end
      end
      ST_COPY: begin
        if (go) begin
          emit   = 1'b1;
          shift  = 1'b1;
          copy_d = copy_q - 3'd1;
        end
      end
      default: ;
    endcase

    if (shift) begin
      for (int k = 0; k < WIN_DEPTH - 1; k++) begin
        win_d[k]     = win_q[k+1];
        win_cls_d[k] = win_cls_q[k+1];
      end
      cnt_d = cnt_q - 3'd1;
    end

    // the held byte learns whether it ends its run only when the next one shows up or the step finishes
    if (emit) begin
      if (hold_vld_q) begin
        out_vld_d    = 1'b1;
        out_byte_d   = hold_byte_q;
        out_run_d    = 1'b0;
        out_stream_d = 1'b0;
      end
      hold_vld_d  = 1'b1;
      hold_byte_d = emit_byte;
    end

    if (finish) begin
      if (hold_vld_q) begin
        out_vld_d    = 1'b1;
        out_byte_d   = hold_byte_q;
        out_run_d    = 1'b1;
        out_stream_d = last_q;
      end
      hold_vld_d = 1'b0;
      take       = 1'b1;
    end

    // lone ascii byte with nothing held goes straight out
    if (fast) begin
      out_vld_d    = 1'b1;
      out_byte_d   = win_q[0];
      out_run_d    = 1'b1;
      out_stream_d = last_q;
      cnt_d        = 3'd0;
      take         = 1'b1;
      take_idx     = 2'd0;
    end

    if (take && q_valid_i) begin
      q_ready_o           = 1'b1;
      win_d[take_idx]     = q_item_i.data;
      win_cls_d[take_idx] = q_item_i.cls;
      cnt_d               = {1'b0, take_idx} + 3'd1;
      last_d              = q_item_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= 3'd0;
      last_q     <= 1'b0;
      rep_q      <= 2'd0;
      drop_q     <= 1'b0;
      copy_q     <= 3'd0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      last_q     <= last_d;
      rep_q      <= rep_d;
      drop_q     <= drop_d;
      copy_q     <= copy_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q        <= win_d;
    win_cls_q    <= win_cls_d;
    hold_byte_q  <= hold_byte_d;
    out_byte_q   <= out_byte_d;
    out_run_q    <= out_run_d;
    out_stream_q <= out_stream_d;
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.run_last    = out_run_q;
  assign out_o.stream_last = out_stream_q;

`ifndef SYNTHESIS
  a_idle_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cnt_q <= 3'd3))
    else $error("idle with a window longer than three bytes");
  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !hold_vld_q)
    else $error("idle with an undelivered byte held");
  a_stream_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && last_q) |-> (cnt_q == 3'd0))
    else $error("window left open across a stream end");
  a_stream_on_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stream_q) |-> out_run_q)
    else $error("stream end without run end");
  a_copy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) |-> (copy_q != 3'd0) && (copy_q <= cnt_q))
    else $error("copy runs past the window");
`endif

endmodule

@@ sim/u8s_out_checker.sv @@
// sanitized byte checker: watches both request channels of the utf-8 sanitizer,
// predicts the output bytes of every accepted input byte and compares them in order
// depends on u8s_pkg
`timescale 1ns / 1ps

module u8s_out_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic       run_last_i,
  input  logic       stream_last_i,
  output int         mismatch_count_o,
  output int         outstanding_o,
  output int         bytes_checked_o
);
  import u8s_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_last;
  } san_byte_t;

  san_byte_t   sanitized_q[$];
  logic [7:0]  held_win [4];
  int unsigned held_cnt;

  function automatic int unsigned seq_len(input logic [7:0] b);
    if (b >= 8'hC2 && b <= 8'hDF) return 2;
    if (b >= 8'hE0 && b <= 8'hEF) return 3;
    if (b >= 8'hF0 && b <= 8'hF4) return 4;
    return 0;
  endfunction

  function automatic bit seq_ok(input logic [7:0] w [5], input int unsigned at,
                                input int unsigned len);
    logic [20:0] cp;
    int unsigned k;
    if (len == 2) cp = 21'(w[at][4:0]);
    else if (len == 3) cp = 21'(w[at][3:0]);
    else cp = 21'(w[at][2:0]);
    for (k = 1; k < len; k++) begin
      if (w[at+k][7:6] != 2'b10) return 1'b0;
      cp = (cp << 6) | 21'(w[at+k][5:0]);
    end
    if (len == 2 && cp < CP_MIN2) return 1'b0;
    if (len == 3 && cp < CP_MIN3) return 1'b0;
    if (len == 4 && cp < CP_MIN4) return 1'b0;
    if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) return 1'b0;
    if (cp > CP_MAX) return 1'b0;
    return 1'b1;
  endfunction

  // window bytes held so far plus the new byte are rescanned from the front
  task automatic predict_sanitized(input logic [7:0] b, input logic last);
    logic [7:0]  q [5];
    logic [7:0]  outs [$];
    san_byte_t   nb;
    int unsigned n, i, len, k;
    q = '{default: 8'h00};
    for (k = 0; k < held_cnt; k++) q[k] = held_win[k];
    q[held_cnt] = b;
    n = held_cnt + 1;
    held_cnt = 0;
    i = 0;
    while (i < n) begin
      len = seq_len(q[i]);
      if (q[i] < 8'h80) begin
        outs = {outs, q[i]};
        i++;
      end else if (len == 0) begin
        outs = {outs, REPL_BYTE0, REPL_BYTE1, REPL_BYTE2};
        i++;
      end else if (i + len > n) begin
        held_win = '{default: 8'h00};
        for (k = 0; k < n - i; k++) held_win[k] = q[i+k];
        held_cnt = n - i;
        break;
      end else if (seq_ok(q, i, len)) begin
        for (k = 0; k < len; k++) outs = {outs, q[i+k]};
        i += len;
      end else begin
        outs = {outs, REPL_BYTE0, REPL_BYTE1, REPL_BYTE2};
        i++;
      end
    end
    // stream closed with a window still open
    if (last && held_cnt != 0) begin
      outs = {outs, REPL_BYTE0, REPL_BYTE1, REPL_BYTE2};
      held_win = '{default: 8'h00};
      held_cnt = 0;
    end
    for (k = 0; k < outs.size(); k++) begin
      nb.data        = outs[k];
      nb.run_last    = (k == outs.size() - 1);
      nb.stream_last = nb.run_last && last;
      sanitized_q    = {sanitized_q, nb};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    san_byte_t want;
    if (!rst_ni) begin
      sanitized_q.delete();
      held_win = '{default: 8'h00};
      held_cnt = 0;
      mismatch_count_o = 0;
      bytes_checked_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) predict_sanitized(in_byte_i, in_last_i);
      if (out_valid_i && out_ready_i) begin
        bytes_checked_o++;
        if (sanitized_q.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("%0t: unexpected output byte %02h run_last %b stream_last %b",
                     $time, out_byte_i, run_last_i, stream_last_i);
          mismatch_count_o++;
        end else begin
          want = sanitized_q.pop_front();
          if (want.data != out_byte_i || want.run_last != run_last_i ||
              want.stream_last != stream_last_i) begin
            if (mismatch_count_o < 10)
              $display("%0t: byte exp %02h/%b/%b got %02h/%b/%b (data/run_last/stream_last)",
                       $time, want.data, want.run_last, want.stream_last,
                       out_byte_i, run_last_i, stream_last_i);
            mismatch_count_o++;
          end
        end
      end
    end
    outstanding_o = sanitized_q.size();
  end

endmodule

@@ sim/tb_top.sv @@
// testbench top of the utf-8 sanitizer: clock, reset, byte stream stimulus,
// random output stalls and the verdict
// depends on u8s_pkg, u8s_if, utf8_lossy_sanitizer_core and u8s_out_checker
`timescale 1ns / 1ps

module tb_top;

  logic clk;
  logic rst_n;
  bit   quiet;
  int   sent_count;
  int   stream_count;
  int   mismatch_count;
  int   outstanding;
  int   bytes_checked;
  logic [7:0] stream_q[$];

  u8s_in_if  in_ch ();
  u8s_out_if out_ch ();

  utf8_lossy_sanitizer_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  u8s_out_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_ch.valid),
    .in_ready_i      (in_ch.ready),
    .in_byte_i       (in_ch.in_byte),
    .in_last_i       (in_ch.in_last),
    .out_valid_i     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .out_byte_i      (out_ch.out_byte),
    .run_last_i      (out_ch.run_last),
    .stream_last_i   (out_ch.stream_last),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding),
    .bytes_checked_o (bytes_checked)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(99) >= 21);
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    if (!quiet) begin
      while ($urandom_range(99) < 21) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= l;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_stream();
    int unsigned k;
    for (k = 0; k < stream_q.size(); k++) send_byte(stream_q[k], k == stream_q.size() - 1);
    stream_q.delete();
    stream_count++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic add_cp(input logic [20:0] cp);
    if (cp < 21'h80) begin
      stream_q = {stream_q, cp[7:0]};
    end else if (cp < 21'h800) begin
      stream_q = {stream_q, {3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
    end else if (cp < 21'h10000) begin
      stream_q = {stream_q, {4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
    end else begin
      stream_q = {stream_q, {5'b11110, cp[20:18]}, {2'b10, cp[17:12]},
                  {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
    end
  endtask

  // random multi-byte scalar value, surrogates skipped
  function automatic logic [20:0] rand_cp();
    logic [20:0] cp;
    case ($urandom_range(2))
      0: cp = 21'($urandom_range(21'h80, 21'h7FF));
      1: begin
        cp = 21'($urandom_range(21'h800, 21'hF7FF));
        if (cp >= 21'hD800) cp += 21'h800;
      end
      default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
    endcase
    return cp;
  endfunction

  task automatic build_random_stream();
    int unsigned tokens, t, base, sel;
    logic [7:0]  lead;
    tokens = $urandom_range(1, 8);
    for (t = 0; t < tokens; t++) begin
      sel = $urandom_range(99);
      base = stream_q.size();
      if (sel < 40) begin
        stream_q = {stream_q, 8'($urandom_range(8'h7F))};
      end else if (sel < 70) begin
        add_cp(rand_cp());
      end else if (sel < 85) begin
        case ($urandom_range(2))
          0: begin
            add_cp(rand_cp());
            stream_q[$urandom_range(base + 1, stream_q.size() - 1)] = 8'($urandom_range(255));
          end
          1: begin
            add_cp(rand_cp());
            void'(stream_q.pop_back());
          end
          default: begin
            // leads near the overlong, surrogate and range limits, then random tails
            if ($urandom_range(1)) begin
              case ($urandom_range(3))
                0: lead = 8'hE0;
                1: lead = 8'hED;
                2: lead = 8'hF0;
                default: lead = 8'hF4;
              endcase
            end else begin
              lead = 8'($urandom_range(8'hC2, 8'hF4));
            end
            stream_q = {stream_q, lead};
            repeat ($urandom_range(1, 3))
              stream_q = {stream_q, 8'($urandom_range(8'h80, 8'hBF))};
          end
        endcase
      end else begin
        stream_q = {stream_q, 8'($urandom_range(255))};
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    quiet = 1'b0;
    sent_count = 0;
    stream_count = 0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // ascii extremes, 2-byte limits, bad continuation
    stream_q = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hC2, 8'h41};
    send_stream();
    // overlong and surrogate windows, end mark on an invalid window
    stream_q = '{8'hE0, 8'h80, 8'h80, 8'hED, 8'hA0, 8'h80};
    send_stream();
    // above range, valid 4-byte, invalid leads and a stray continuation
    stream_q = '{8'hF4, 8'h90, 8'h80, 8'h80, 8'hF0, 8'h90, 8'h80, 8'h80, 8'hC0, 8'hFF, 8'h80};
    send_stream();
    // stream ends inside an open window
    stream_q = '{8'hE2, 8'h82};
    send_stream();
    drain();

    while (sent_count < 470) begin
      build_random_stream();
      quiet = (stream_count >= 20 && stream_count < 32);
      if (stream_count == 14) drain();
      send_stream();
    end

    drain();
    repeat (32) @(negedge clk);
    $display("covered %0d input bytes in %0d streams, %0d output bytes compared",
             sent_count, stream_count, bytes_checked);
    $display("mismatches counted: %0d", mismatch_count);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
